[hdl/tsrb_pkg.sv]
package tsrb_pkg;

    // ring geometry
    localparam int TX_SLOTS         = 2;
    localparam int TX_BUFFERS       = 4;
    localparam int RX_SLOTS         = 2;
    localparam int RX_BUFFERS       = 4;
    localparam int WORDS_PER_BUFFER = 256;

    // idle timeout default: one frame worth of clocks
    localparam int CLOCK_HZ = 200 * 1000 * 1000;
    localparam int FRAME_HZ = 16000;
    localparam logic [23:0] TIMEOUT_RESET = 24'(CLOCK_HZ / FRAME_HZ);

    localparam logic [20:0] STRIDE_RESET = 21'd4096;

    // slot index fits 32 slots, row index fits 32 slots times 16 buffers
    localparam int SLOT_W = 5;
    localparam int ROW_W  = 9;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_TX      = 2'd1,
        ACT_RX      = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_BASE      = 3'd0,
        REG_RX_OFFSET = 3'd1,
        REG_STRIDE    = 3'd2,
        REG_TX_EN     = 3'd3,
        REG_RX_EN     = 3'd4,
        REG_TIMEOUT   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] base_address;
        logic [31:0] rx_offset;
        logic [20:0] buffer_stride;
        logic        tx_enable;
        logic        rx_enable;
        logic [23:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic        data_ready;
        logic        error_flag;
        logic [8:0]  slot_count;
        logic [31:0] rx_sample;
    } poll_t;

    // decoded beat waiting for the address multiply
    typedef struct packed {
        action_t          action;
        logic [31:0]      region;
        logic [ROW_W-1:0] row;
        logic [7:0]       word;
        logic [31:0]      data;
        logic             notify;
        logic             direction;
        logic [3:0]       nbuf;
    } op_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        notify;
        logic        direction;
        logic [3:0]  nbuf;
    } res_t;

endpackage

[hdl/tsrb_ctrl.sv]
module tsrb_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  tsrb_pkg::cfg_t  cfg,
    input  tsrb_pkg::poll_t poll,
    input  logic           update,
    output tsrb_pkg::op_t   op
);
    import tsrb_pkg::*;

    logic [7:0]  tx_word_reg, tx_word_next;
    logic [3:0]  tx_buf_reg, tx_buf_next;
    logic [7:0]  rx_word_reg, rx_word_next;
    logic [3:0]  rx_buf_reg, rx_buf_next;
    logic [23:0] idle_reg, idle_next;

    logic [9:0]  tx_slot;
    logic [9:0]  rx_slot;
    logic [8:0]  tx_word_inc;
    logic [8:0]  rx_word_inc;
    logic [4:0]  tx_buf_inc;
    logic [4:0]  rx_buf_inc;
    logic [23:0] idle_inc;
    logic [SLOT_W-1:0] slot_sel;

    // slot and counter increments
    always_comb
    begin
        tx_slot     = {1'b0, poll.slot_count} + 10'd1;
        rx_slot     = (poll.slot_count != 9'd0) ? ({1'b0, poll.slot_count} - 10'd1)
                                                : 10'(RX_SLOTS - 1);
        tx_word_inc = {1'b0, tx_word_reg} + 9'd1;
        rx_word_inc = {1'b0, rx_word_reg} + 9'd1;
        tx_buf_inc  = {1'b0, tx_buf_reg} + 5'd1;
        rx_buf_inc  = {1'b0, rx_buf_reg} + 5'd1;
        idle_inc    = idle_reg + 24'd1;
    end

    // poll decode and next state
    always_comb
    begin
        tx_word_next = tx_word_reg;
        tx_buf_next  = tx_buf_reg;
        rx_word_next = rx_word_reg;
        rx_buf_next  = rx_buf_reg;
        idle_next    = idle_reg;
        slot_sel     = '0;
        op           = '0;
        op.action    = ACT_NONE;

        if (!poll.command)
        begin
            if (!cfg.tx_enable)
            begin
                op.action = ACT_NONE;
            end
            else if (poll.error_flag)
            begin
                op.action = ACT_RESTART;
            end
            else if (!poll.data_ready)
            begin
                // idle poll, time out when the count hits the limit
                if (idle_inc >= cfg.timeout_limit)
                begin
                    idle_next = '0;
                    op.action = ACT_RESTART;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
            else if (tx_slot > 10'(TX_SLOTS))
            begin
                op.action = ACT_RESTART;
            end
            else
            begin
                op.action = ACT_TX;
                idle_next = '0;
                slot_sel  = SLOT_W'(tx_slot);
                if (tx_slot == 10'(TX_SLOTS))
                begin
                    slot_sel = '0;
                    if (tx_word_inc >= 9'(WORDS_PER_BUFFER))
                    begin
                        tx_word_next = '0;
                        tx_buf_next  = (tx_buf_inc >= 5'(TX_BUFFERS)) ? 4'd0
                                                                      : tx_buf_inc[3:0];
                        op.notify    = 1'b1;
                        op.nbuf      = tx_buf_next;
                    end
                    else
                    begin
                        tx_word_next = tx_word_inc[7:0];
                    end
                end
                op.region = cfg.base_address;
                op.row    = ROW_W'(slot_sel) * ROW_W'(TX_BUFFERS) + ROW_W'(tx_buf_next);
                op.word   = tx_word_next;
            end
        end
        else
        begin
            if (!cfg.rx_enable)
            begin
                op.action = ACT_NONE;
            end
            else if (poll.error_flag)
            begin
                op.action = ACT_RESTART;
            end
            else if (!poll.data_ready)
            begin
                op.action = ACT_NONE;
            end
            else if (rx_slot >= 10'(RX_SLOTS))
            begin
                op.action = ACT_RESTART;
            end
            else
            begin
                op.action = ACT_RX;
                slot_sel  = SLOT_W'(rx_slot);
                if (rx_slot == 10'd0)
                begin
                    if (rx_word_inc >= 9'(WORDS_PER_BUFFER))
                    begin
                        rx_word_next = '0;
                        rx_buf_next  = (rx_buf_inc >= 5'(RX_BUFFERS)) ? 4'd0
                                                                      : rx_buf_inc[3:0];
                        op.notify    = 1'b1;
                        op.direction = 1'b1;
                        op.nbuf      = rx_buf_next;
                    end
                    else
                    begin
                        rx_word_next = rx_word_inc[7:0];
                    end
                end
                op.region = cfg.base_address + cfg.rx_offset;
                op.row    = ROW_W'(slot_sel) * ROW_W'(RX_BUFFERS) + ROW_W'(rx_buf_next);
                op.word   = rx_word_next;
                op.data   = poll.rx_sample;
            end
        end
    end

    // ring state, advanced once per beat leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_word_reg <= '0;
            tx_buf_reg  <= '0;
            rx_word_reg <= '0;
            rx_buf_reg  <= '0;
            idle_reg    <= '0;
        end
        else if (update)
        begin
            tx_word_reg <= tx_word_next;
            tx_buf_reg  <= tx_buf_next;
            rx_word_reg <= rx_word_next;
            rx_buf_reg  <= rx_buf_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

[hdl/tsrb_addr.sv]
module tsrb_addr
(
    input  tsrb_pkg::op_t  op,
    input  logic [20:0]    buffer_stride,
    output tsrb_pkg::res_t res
);
    import tsrb_pkg::*;

    logic [29:0] row_offset;
    logic [31:0] word_offset;
    logic [31:0] sum;

    // region + row * stride + word * 4, wrapping at 32 bits
    always_comb
    begin
        row_offset  = 30'(op.row) * 30'(buffer_stride);
        word_offset = {22'd0, op.word, 2'b00};
        sum         = op.region + {2'b00, row_offset} + word_offset;
    end

    // only memory actions carry an address
    always_comb
    begin
        res.action     = op.action;
        res.address    = ((op.action == ACT_TX) || (op.action == ACT_RX)) ? sum : 32'd0;
        res.write_data = (op.action == ACT_RX) ? op.data : 32'd0;
        res.notify     = op.notify;
        res.direction  = op.direction;
        res.nbuf       = op.nbuf;
    end

endmodule

[hdl/tdm_slot_ring_buffer_addresser.sv]
// pipeline: input register, decode register, result register; the address multiply
// has a stage of its own, and a stall at the output can back up through the stages
// throughput: one poll per cycle while out_stall is low
// reset: asynchronous active low; pipeline empties, ring counters and idle count
// clear, registers take their defaults (stride 4096, timeout limit 12500)
module tdm_slot_ring_buffer_addresser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic        data_ready,
    input  logic        error_flag,
    input  logic [8:0]  slot_count,
    input  logic [31:0] rx_sample,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [31:0] address,
    output logic [31:0] write_data,
    output logic        notify,
    output logic        notify_direction,
    output logic [3:0]  notify_buffer
);
    import tsrb_pkg::*;

    cfg_t  cfg_reg;
    poll_t s1_reg;
    logic  s1_valid_reg;
    op_t   s2_reg;
    logic  s2_valid_reg;
    res_t  out_reg;
    logic  out_valid_reg;

    op_t   op;
    res_t  res;
    logic  out_free;
    logic  s2_free;
    logic  s1_free;
    logic  s1_move;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address  <= '0;
            cfg_reg.rx_offset     <= '0;
            cfg_reg.buffer_stride <= STRIDE_RESET;
            cfg_reg.tx_enable     <= 1'b0;
            cfg_reg.rx_enable     <= 1'b0;
            cfg_reg.timeout_limit <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE:      cfg_reg.base_address  <= cfg_data;
                REG_RX_OFFSET: cfg_reg.rx_offset     <= cfg_data;
                REG_STRIDE:    cfg_reg.buffer_stride <= cfg_data[20:0];
                REG_TX_EN:     cfg_reg.tx_enable     <= cfg_data[0];
                REG_RX_EN:     cfg_reg.rx_enable     <= cfg_data[0];
                REG_TIMEOUT:   cfg_reg.timeout_limit <= cfg_data[23:0];
                default:       ;
            endcase
        end
    end

    // pipeline flow control, a stage takes a beat when empty or draining
    assign out_free = ~out_valid_reg | ~out_stall;
    assign s2_free  = ~s2_valid_reg | out_free;
    assign s1_free  = ~s1_valid_reg | s2_free;
    assign s1_move  = s1_valid_reg & s2_free;
    assign in_stall = ~s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            s1_reg.command    <= command;
            s1_reg.data_ready <= data_ready;
            s1_reg.error_flag <= error_flag;
            s1_reg.slot_count <= slot_count;
            s1_reg.rx_sample  <= rx_sample;
        end
        if (s1_move)
        begin
            s2_reg <= op;
        end
        if (out_free && s2_valid_reg)
        begin
            out_reg <= res;
        end
    end

    // decode and ring state
    tsrb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .poll   (s1_reg),
        .update (s1_move),
        .op     (op)
    );

    // address arithmetic
    tsrb_addr u_addr
    (
        .op            (s2_reg),
        .buffer_stride (cfg_reg.buffer_stride),
        .res           (res)
    );

    assign out_valid        = out_valid_reg;
    assign action           = out_reg.action;
    assign address          = out_reg.address;
    assign write_data       = out_reg.write_data;
    assign notify           = out_reg.notify;
    assign notify_direction = out_reg.direction;
    assign notify_buffer    = out_reg.nbuf;

endmodule

[hdl/tsrb_check.sv]
module tsrb_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  action,
    input logic [31:0] address,
    input logic [31:0] write_data,
    input logic        notify,
    input logic        notify_direction,
    input logic [3:0]  notify_buffer
);
    import tsrb_pkg::*;

    // a stalled result beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(address) && $stable(action))
    else $error("stalled result beat changed");

    // no address for idle or restart answers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_NONE || action == ACT_RESTART)
        |-> address == 32'd0 && write_data == 32'd0)
    else $error("address or data on a non memory action");

    // write data only on receive writes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_RX |-> write_data == 32'd0)
    else $error("write data outside a receive write");

    // notification only with a memory access, fields quiet otherwise
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify |-> (action == ACT_TX || action == ACT_RX)
        && notify_direction == (action == ACT_RX))
    else $error("notification without matching access");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !notify |-> !notify_direction && notify_buffer == 4'd0)
    else $error("notification fields set without notify");

endmodule

bind tdm_slot_ring_buffer_addresser tsrb_check u_tsrb_check
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .action           (action),
    .address          (address),
    .write_data       (write_data),
    .notify           (notify),
    .notify_direction (notify_direction),
    .notify_buffer    (notify_buffer)
);
